// ----- sv/csnw_pkg.sv -----
`default_nettype none
package csnw_pkg;

  // axis count
  localparam int MAX_AXES = 3;
  localparam int AXES_DEF = 3;

  // field widths
  localparam int OFF_W  = 32;
  localparam int EDGE_W = 2;
  localparam int INV_W  = 32;
  localparam int W_W    = 32;
  localparam int GRAD_W = 48;
  localparam int CFG_IDX_W = 2;

  // internal widths
  localparam int MAG_IN_W = OFF_W + 1;
  localparam int RM_W     = MAG_IN_W + INV_W;
  localparam int R_W      = 33;
  localparam int ARG_W    = 36;
  localparam int X_W      = 31;
  localparam int VAL_W    = 36;
  localparam int MAG_W    = 35;
  localparam int GM_W     = MAG_W + INV_W;
  localparam int RES_W    = GM_W - 30;

  // pipeline depth
  localparam int LANE_STAGES  = 5;
  localparam int MERGE_STAGES = 4;
  localparam int STAGES       = LANE_STAGES + MERGE_STAGES;

  // fixed point constants
  localparam logic [ARG_W-1:0] ONE_Q30 = 36'h0_4000_0000;
  localparam logic [ARG_W-1:0] TWO_Q30 = 36'h0_8000_0000;
  localparam logic signed [VAL_W-1:0] ONE_VAL = 36'sh0_4000_0000;
  localparam logic signed [VAL_W-1:0] TWO_THIRDS_Q30 = 36'sd715827883;
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
  localparam logic [RM_W-1:0] R_CLAMP = 65'h4_0000_0000;
  localparam logic [INV_W-1:0] INV_RESET = 32'h0001_0000;

  // edge classes
  typedef enum logic [EDGE_W-1:0] {
    EDGE_BOUNDARY = 2'd0,
    EDGE_START    = 2'd1,
    EDGE_END      = 2'd2,
    EDGE_INTERIOR = 2'd3
  } edge_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INV_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Z = 2'd2;

  // stage load enables
  typedef struct packed {
    logic [LANE_STAGES-1:0] load;
  } lane_ctl_t;

  typedef struct packed {
    logic [MERGE_STAGES-1:0] load;
  } merge_ctl_t;

  // q.30 product truncated toward zero
  function automatic logic signed [VAL_W-1:0] mul_q30(
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] b
  );
    logic [MAG_W-1:0] ma;
    logic [MAG_W-1:0] mb;
    logic [2*MAG_W-1:0] p;
    logic [MAG_W-1:0] pm;
    logic signed [VAL_W-1:0] ps;
    ma = a[VAL_W-1] ? MAG_W'(-a) : MAG_W'(a);
    mb = b[VAL_W-1] ? MAG_W'(-b) : MAG_W'(b);
    p  = ma * mb;
    pm = p[MAG_W+29:30];
    ps = {1'b0, pm};
    return (a[VAL_W-1] ^ b[VAL_W-1]) ? -ps : ps;
  endfunction

endpackage
`default_nettype wire

// ----- sv/csnw_spline.sv -----
`default_nettype none
module csnw_spline (
  input  wire logic clk,
  input  wire logic [3:0] load,
  input  wire logic signed [csnw_pkg::ARG_W-1:0] arg,
  output logic signed [csnw_pkg::VAL_W-1:0] s_val,
  output logic signed [csnw_pkg::VAL_W-1:0] g_val
);

  localparam int ARG_W = csnw_pkg::ARG_W;
  localparam int X_W   = csnw_pkg::X_W;
  localparam int VAL_W = csnw_pkg::VAL_W;

  // magnitude and region of the argument
  logic arg_neg;
  logic [ARG_W-1:0] u;
  logic [ARG_W-1:0] w_full;
  logic ge2, lt1;
  logic [X_W-1:0] x;
  logic [2*X_W-1:0] sq_full;

  assign arg_neg = arg[ARG_W-1];
  assign u       = arg_neg ? ARG_W'(-arg) : ARG_W'(arg);
  assign ge2     = u >= csnw_pkg::TWO_Q30;
  assign lt1     = u < csnw_pkg::ONE_Q30;
  assign w_full  = csnw_pkg::TWO_Q30 - u;
  assign x       = lt1 ? u[X_W-1:0] : w_full[X_W-1:0];
  assign sq_full = x * x;

  // stage a: square
  logic [X_W-1:0] x_a, sq_a;
  logic lt1_a, ge2_a, neg_a;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      x_a   <= x;
      sq_a  <= sq_full[X_W+29:30];
      lt1_a <= lt1;
      ge2_a <= ge2;
      neg_a <= arg_neg;
    end
  end

  // stage b: cube and derivative
  logic [2*X_W-1:0] cube_full;
  logic [X_W+1:0] tri_sq;
  logic signed [VAL_W-1:0] m, g_b_next;

  assign cube_full = sq_a * x_a;
  assign tri_sq    = {2'b00, sq_a} + {1'b0, sq_a, 1'b0};

  always_comb begin
    if (ge2_a) begin
      m = '0;
    end else if (lt1_a) begin
      m = VAL_W'(tri_sq >> 1) - VAL_W'({x_a, 1'b0});
    end else begin
      m = -VAL_W'(sq_a >> 1);
    end
    g_b_next = neg_a ? -m : m;
  end

  logic [X_W-1:0] cube_b, sq_b;
  logic lt1_b, ge2_b;
  logic signed [VAL_W-1:0] g_b;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      cube_b <= cube_full[X_W+29:30];
      sq_b   <= sq_a;
      lt1_b  <= lt1_a;
      ge2_b  <= ge2_a;
      g_b    <= g_b_next;
    end
  end

  // stage c: inner polynomial and divide by six through reciprocal
  logic [X_W-2:0] half_cube;
  logic signed [VAL_W-1:0] small_next;
  assign half_cube  = cube_b[X_W-1:1];
  assign small_next = VAL_W'(half_cube) - VAL_W'(sq_b) + csnw_pkg::TWO_THIRDS_Q30;

  logic signed [VAL_W-1:0] small_c, g_c;
  logic [X_W+30:0] div_c;
  logic lt1_c, ge2_c;

  always_ff @(posedge clk) begin
    if (load[2]) begin
      small_c <= small_next;
      div_c   <= half_cube * csnw_pkg::RECIP3;
      lt1_c   <= lt1_b;
      ge2_c   <= ge2_b;
      g_c     <= g_b;
    end
  end

  // stage d: select region
  logic signed [VAL_W-1:0] s_next;
  always_comb begin
    if (ge2_c) begin
      s_next = '0;
    end else if (lt1_c) begin
      s_next = small_c;
    end else begin
      s_next = VAL_W'(div_c[X_W+30:33]);
    end
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      s_val <= s_next;
      g_val <= g_c;
    end
  end

endmodule
`default_nettype wire

// ----- sv/csnw_lane.sv -----
`default_nettype none
module csnw_lane (
  input  wire logic clk,
  input  wire csnw_pkg::lane_ctl_t ctl,
  input  wire logic signed [csnw_pkg::OFF_W-1:0] offset,
  input  wire logic [csnw_pkg::EDGE_W-1:0] edge_cls,
  input  wire logic [csnw_pkg::INV_W-1:0] inv,
  output logic signed [csnw_pkg::VAL_W-1:0] val,
  output logic signed [csnw_pkg::VAL_W-1:0] der
);

  localparam int OFF_W    = csnw_pkg::OFF_W;
  localparam int MAG_IN_W = csnw_pkg::MAG_IN_W;
  localparam int RM_W     = csnw_pkg::RM_W;
  localparam int R_W      = csnw_pkg::R_W;
  localparam int ARG_W    = csnw_pkg::ARG_W;
  localparam int VAL_W    = csnw_pkg::VAL_W;

  // stage 0: scaled magnitude of the offset
  logic [MAG_IN_W-1:0] mag;
  assign mag = offset[OFF_W-1] ? (33'h1_0000_0000 - {1'b0, offset}) : {1'b0, offset};

  logic [RM_W-1:0] rm_q;
  logic neg_q;
  csnw_pkg::edge_t edge_q;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      rm_q   <= mag * inv;
      neg_q  <= offset[OFF_W-1];
      edge_q <= csnw_pkg::edge_t'(edge_cls);
    end
  end

  // clamp, truncate to q.30 and form the two spline arguments
  logic [RM_W-1:0] rmc;
  logic [R_W-1:0] rmag;
  logic rneg;
  logic signed [ARG_W-1:0] rext, r, a1;

  assign rmc  = (rm_q > csnw_pkg::R_CLAMP) ? csnw_pkg::R_CLAMP : rm_q;
  assign rmag = rmc[R_W+1:2];
  assign rneg = neg_q && (rmag != '0);
  assign rext = ARG_W'(rmag);
  assign r    = rneg ? -rext : rext;

  always_comb begin
    unique case (edge_q)
      csnw_pkg::EDGE_START:    a1 = r + ARG_W'(csnw_pkg::TWO_Q30);
      csnw_pkg::EDGE_END:      a1 = r - ARG_W'(csnw_pkg::TWO_Q30);
      csnw_pkg::EDGE_BOUNDARY: a1 = rneg ? (r - ARG_W'(csnw_pkg::ONE_Q30))
                                         : (r + ARG_W'(csnw_pkg::ONE_Q30));
      csnw_pkg::EDGE_INTERIOR: a1 = r;
      default:                 a1 = r;
    endcase
  end

  // spline evaluators
  logic signed [VAL_W-1:0] s0, g0, s1, g1;

  csnw_spline u_spl0 (
    .clk   (clk),
    .load  (ctl.load[4:1]),
    .arg   (r),
    .s_val (s0),
    .g_val (g0)
  );

  csnw_spline u_spl1 (
    .clk   (clk),
    .load  (ctl.load[4:1]),
    .arg   (a1),
    .s_val (s1),
    .g_val (g1)
  );

  // edge class follows the spline pipeline
  csnw_pkg::edge_t edge_p [1:4];
  always_ff @(posedge clk) begin
    if (ctl.load[1]) edge_p[1] <= edge_q;
    if (ctl.load[2]) edge_p[2] <= edge_p[1];
    if (ctl.load[3]) edge_p[3] <= edge_p[2];
    if (ctl.load[4]) edge_p[4] <= edge_p[3];
  end

  // combine shifted splines per edge class
  always_comb begin
    unique case (edge_p[4])
      csnw_pkg::EDGE_INTERIOR: begin
        val = s0;
        der = g0;
      end
      csnw_pkg::EDGE_START, csnw_pkg::EDGE_END: begin
        val = s0 - s1;
        der = g0 - g1;
      end
      csnw_pkg::EDGE_BOUNDARY: begin
        val = s0 + (s1 <<< 1);
        der = g0 + (g1 <<< 1);
      end
      default: begin
        val = s0;
        der = g0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/csnw_merge.sv -----
`default_nettype none
module csnw_merge #(
  parameter int AXES = csnw_pkg::AXES_DEF
) (
  input  wire logic clk,
  input  wire csnw_pkg::merge_ctl_t ctl,
  input  wire logic signed [csnw_pkg::VAL_W-1:0] val [csnw_pkg::MAX_AXES],
  input  wire logic signed [csnw_pkg::VAL_W-1:0] der [csnw_pkg::MAX_AXES],
  input  wire logic [csnw_pkg::INV_W-1:0] inv [csnw_pkg::MAX_AXES],
  output logic signed [csnw_pkg::W_W-1:0] weight,
  output logic signed [csnw_pkg::GRAD_W-1:0] grad [csnw_pkg::MAX_AXES]
);

  localparam int N      = csnw_pkg::MAX_AXES;
  localparam int VAL_W  = csnw_pkg::VAL_W;
  localparam int MAG_W  = csnw_pkg::MAG_W;
  localparam int GM_W   = csnw_pkg::GM_W;
  localparam int RES_W  = csnw_pkg::RES_W;
  localparam int W_W    = csnw_pkg::W_W;
  localparam int GRAD_W = csnw_pkg::GRAD_W;

  // stage a: pair products
  logic signed [VAL_W-1:0] w01_a, p0_a, p1_a, v2_a;
  logic signed [VAL_W-1:0] d_a [N];

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      w01_a <= csnw_pkg::mul_q30(val[0], val[1]);
      p0_a  <= csnw_pkg::mul_q30(val[1], val[2]);
      p1_a  <= csnw_pkg::mul_q30(val[0], val[2]);
      v2_a  <= val[2];
      d_a   <= der;
    end
  end

  // stage b: full weight and derivative times other axes
  logic signed [VAL_W-1:0] w_b;
  logic signed [VAL_W-1:0] q_b [N];

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      w_b    <= csnw_pkg::mul_q30(w01_a, v2_a);
      q_b[0] <= csnw_pkg::mul_q30(d_a[0], p0_a);
      q_b[1] <= csnw_pkg::mul_q30(d_a[1], p1_a);
      q_b[2] <= csnw_pkg::mul_q30(d_a[2], w01_a);
    end
  end

  // stage c: weight saturation and spacing scale
  logic signed [W_W-1:0] w_sat;
  always_comb begin
    if (w_b > VAL_W'(64'sh7FFF_FFFF)) begin
      w_sat = 32'sh7FFF_FFFF;
    end else if (w_b < -VAL_W'(64'sh8000_0000)) begin
      w_sat = 32'sh8000_0000;
    end else begin
      w_sat = w_b[W_W-1:0];
    end
  end

  logic signed [W_W-1:0] w_c;
  logic [GM_W-1:0] gm_c [N];
  logic gneg_c [N];

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      w_c <= w_sat;
      for (int i = 0; i < N; i++) begin
        gm_c[i]   <= (q_b[i][VAL_W-1] ? MAG_W'(-q_b[i]) : MAG_W'(q_b[i])) * inv[i];
        gneg_c[i] <= q_b[i][VAL_W-1];
      end
    end
  end

  // stage d: truncate to q.16 and saturate
  logic [RES_W-1:0] res [N];
  logic [GRAD_W:0] res_e [N];
  logic signed [GRAD_W-1:0] g_next [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      res[i]   = gm_c[i][GM_W-1:30];
      res_e[i] = (GRAD_W+1)'(res[i]);
      if (i >= AXES) begin
        g_next[i] = '0;
      end else if (gneg_c[i]) begin
        if (res_e[i] > 49'h0_8000_0000_0000) begin
          g_next[i] = 48'sh8000_0000_0000;
        end else begin
          g_next[i] = -GRAD_W'(res_e[i]);
        end
      end else if (res_e[i] > 49'h0_7FFF_FFFF_FFFF) begin
        g_next[i] = 48'sh7FFF_FFFF_FFFF;
      end else begin
        g_next[i] = GRAD_W'(res_e[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      weight <= w_c;
      grad   <= g_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/cubic_spline_node_weight_top.sv -----
`default_nettype none
// channel   dir  signals                         contents
// s_axis    in   tvalid tready tdata[95:0]       offsets x, y, z; tuser edge classes
// m_axis    out  tvalid tready tdata[175:0]      weight, grad x, y, z
// cfg       in   cfg_we cfg_index cfg_data       inv_spacing x, y, z
//
// one transaction per cycle sustained while m_axis_tready is high; the stages
// of the multiplier pipeline are scale, square, cube, reciprocal divide, region
// select, two product stages, spacing scale and saturation; one lane per axis
// rst is synchronous and empties the pipeline; spacing registers reset to 1.0
// a stalled output holds only the stages behind it that are full; bubbles
// close up, so input is taken while any stage is empty
module cubic_spline_node_weight_top #(
  parameter int AXES = csnw_pkg::AXES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // offset_x, offset_y, offset_z
  input  wire logic [95:0] s_axis_tdata,
  // edge_x, edge_y, edge_z
  input  wire logic [5:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  // weight, grad_x, grad_y, grad_z
  output logic [175:0] m_axis_tdata,
  input  wire logic cfg_we,
  input  wire logic [csnw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [csnw_pkg::INV_W-1:0] cfg_data
);

  localparam int N      = csnw_pkg::MAX_AXES;
  localparam int STAGES = csnw_pkg::STAGES;
  localparam int LS     = csnw_pkg::LANE_STAGES;
  localparam int OFF_W  = csnw_pkg::OFF_W;
  localparam int EDGE_W = csnw_pkg::EDGE_W;
  localparam int VAL_W  = csnw_pkg::VAL_W;

  // spacing registers
  logic [csnw_pkg::INV_W-1:0] inv [N];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) inv[i] <= csnw_pkg::INV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csnw_pkg::REG_INV_X: inv[0] <= cfg_data;
        csnw_pkg::REG_INV_Y: inv[1] <= cfg_data;
        csnw_pkg::REG_INV_Z: inv[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valid bits with bubble collapse
  logic [STAGES-1:0] v, adv, v_next;
  always_comb begin
    adv[STAGES-1] = !v[STAGES-1] || m_axis_tready;
    for (int k = STAGES - 2; k >= 0; k--) adv[k] = !v[k] || adv[k+1];
    v_next = (adv & {v[STAGES-2:0], s_axis_tvalid}) | (~adv & v);
  end

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else     v <= v_next;
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = v[STAGES-1];

  csnw_pkg::lane_ctl_t lane_ctl;
  csnw_pkg::merge_ctl_t merge_ctl;
  assign lane_ctl.load  = adv[LS-1:0];
  assign merge_ctl.load = adv[STAGES-1:LS];

  // per-axis lanes; absent axes contribute 1.0
  logic signed [VAL_W-1:0] val [N];
  logic signed [VAL_W-1:0] der [N];

  for (genvar i = 0; i < N; i++) begin : g_lane
    if (i < AXES) begin : g_on
      csnw_lane u_lane (
        .clk      (clk),
        .ctl      (lane_ctl),
        .offset   (s_axis_tdata[i*OFF_W +: OFF_W]),
        .edge_cls (s_axis_tuser[i*EDGE_W +: EDGE_W]),
        .inv      (inv[i]),
        .val      (val[i]),
        .der      (der[i])
      );
    end else begin : g_off
      assign val[i] = csnw_pkg::ONE_VAL;
      assign der[i] = '0;
    end
  end

  // products, scaling and saturation
  logic signed [csnw_pkg::W_W-1:0] weight;
  logic signed [csnw_pkg::GRAD_W-1:0] grad [N];

  csnw_merge #(
    .AXES (AXES)
  ) u_merge (
    .clk    (clk),
    .ctl    (merge_ctl),
    .val    (val),
    .der    (der),
    .inv    (inv),
    .weight (weight),
    .grad   (grad)
  );

  assign m_axis_tdata = {grad[2], grad[1], grad[0], weight};

  // any empty stage lets a transaction in
  a_ready_bubble: assert property (@(posedge clk) disable iff (rst)
    !(&v) |-> s_axis_tready) else $error("input stalled with an empty stage");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (v == '0)) else $error("pipeline not empty after reset");

  // a result only appears when the stage before it held one
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(v[STAGES-2])) else $error("result from nowhere");

  // an absent z axis gives zero gradient
  a_unused_axis: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (AXES < 3)) |-> (m_axis_tdata[175:128] == '0))
    else $error("gradient on an absent axis");

endmodule
`default_nettype wire

// ----- sim/tb_cubic_spline_node_weight_top.sv -----
`timescale 1ns / 1ps

// queue of predicted results and their comparison
class weight_scoreboard;
  logic [175:0] pending[$];
  int errors;

  function void note_input(logic [175:0] expected);
    pending.insert(pending.size(), expected);
  endfunction

  function void check_result(logic [175:0] actual);
    logic [175:0] e;
    if (pending.size() == 0) begin
      $display("%0t: result with none pending, actual %h", $time, actual);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e[31:0] !== actual[31:0]) begin
      $display("%0t: weight expected %h actual %h", $time, e[31:0], actual[31:0]);
      errors++;
    end
    if (e[79:32] !== actual[79:32]) begin
      $display("%0t: grad_x expected %h actual %h", $time, e[79:32], actual[79:32]);
      errors++;
    end
    if (e[127:80] !== actual[127:80]) begin
      $display("%0t: grad_y expected %h actual %h", $time, e[127:80], actual[127:80]);
      errors++;
    end
    if (e[175:128] !== actual[175:128]) begin
      $display("%0t: grad_z expected %h actual %h", $time, e[175:128],
               actual[175:128]);
      errors++;
    end
  endfunction
endclass

module tb_cubic_spline_node_weight_top;
  localparam longint GMAX = 64'sd140737488355327;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [5:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [175:0] m_axis_tdata;
  logic cfg_we = 0;
  logic [csnw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [csnw_pkg::INV_W-1:0] cfg_data = '0;

  logic [31:0] spacing[3];
  int send_idle, recv_idle;
  longint cycles;
  weight_scoreboard sb;

  cubic_spline_node_weight_top dut (.*);

  always #5 clk = ~clk;

  function automatic longint mag64(longint a);
    return a < 0 ? -a : a;
  endfunction

  // shape value on a q.30 argument
  function automatic longint shape_val(longint a);
    longint u, v2, v3, w;
    u = mag64(a);
    if (u >= 64'sd2147483648) return 0;
    if (u < 64'sd1073741824) begin
      v2 = (u * u) >>> 30;
      v3 = (v2 * u) >>> 30;
      return (v3 >>> 1) - v2 + 64'sd715827883;
    end
    w = 64'sd2147483648 - u;
    return ((((w * w) >>> 30) * w) >>> 30) / 6;
  endfunction

  // shape derivative on a q.30 argument
  function automatic longint shape_der(longint a);
    longint u, v2, m, w;
    u = mag64(a);
    if (u >= 64'sd2147483648) return 0;
    if (u < 64'sd1073741824) begin
      v2 = (u * u) >>> 30;
      m = ((3 * v2) >>> 1) - 2 * u;
    end else begin
      w = 64'sd2147483648 - u;
      m = -(((w * w) >>> 30) >>> 1);
    end
    return a < 0 ? -m : m;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    logic [127:0] p;
    longint r;
    p = 128'(mag64(a)) * 128'(mag64(b));
    r = longint'(p >> 30);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // q.30 times q16.16 spacing down to q.16, saturated
  function automatic longint grad_scale(longint q, logic [31:0] inv);
    logic [127:0] p;
    longint r;
    p = (128'(mag64(q)) * 128'(inv)) >> 30;
    if (p > 128'(GMAX) + 1) p = 128'(GMAX) + 1;
    r = longint'(p);
    if (q < 0) return -r;
    return r > GMAX ? GMAX : r;
  endfunction

  function automatic logic [175:0] predict_weights(logic [95:0] offs, logic [5:0] edges);
    longint v[3], d[3], r, w, p, g;
    logic [63:0] rm;
    logic [31:0] b;
    logic [175:0] res;
    csnw_pkg::edge_t ec;
    for (int i = 0; i < 3; i++) begin
      b = offs[32*i +: 32];
      rm = (b[31] ? (64'h1_0000_0000 - 64'(b)) : 64'(b)) * 64'(spacing[i]);
      if (rm > 64'h4_0000_0000) rm = 64'h4_0000_0000;
      r = longint'(rm >> 2);
      if (b[31]) r = -r;
      ec = csnw_pkg::edge_t'(edges[2*i +: 2]);
      case (ec)
        csnw_pkg::EDGE_INTERIOR: begin
          v[i] = shape_val(r);
          d[i] = shape_der(r);
        end
        csnw_pkg::EDGE_START: begin
          v[i] = shape_val(r) - shape_val(r + 64'sd2147483648);
          d[i] = shape_der(r) - shape_der(r + 64'sd2147483648);
        end
        csnw_pkg::EDGE_END: begin
          v[i] = shape_val(r) - shape_val(r - 64'sd2147483648);
          d[i] = shape_der(r) - shape_der(r - 64'sd2147483648);
        end
        default: begin
          v[i] = shape_val(r) + 2 * shape_val(mag64(r) + 64'sd1073741824);
          if (r >= 0) d[i] = shape_der(r) + 2 * shape_der(r + 64'sd1073741824);
          else d[i] = shape_der(r) + 2 * shape_der(r - 64'sd1073741824);
        end
      endcase
    end
    w = 64'sd1073741824;
    for (int i = 0; i < 3; i++) w = q30_mul(w, v[i]);
    if (w > 64'sd2147483647) w = 64'sd2147483647;
    if (w < -64'sd2147483648) w = -64'sd2147483648;
    res[31:0] = w[31:0];
    for (int i = 0; i < 3; i++) begin
      p = 64'sd1073741824;
      for (int j = 0; j < 3; j++) if (j != i) p = q30_mul(p, v[j]);
      g = grad_scale(q30_mul(d[i], p), spacing[i]);
      if (g < -GMAX - 1) g = -GMAX - 1;
      res[32 + 48*i +: 48] = g[47:0];
    end
    return res;
  endfunction

  // offsets mostly near the spline support, sometimes wild
  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000);
    endcase
  endfunction

  // valid stays up between transactions unless the sender idles
  task automatic send_item(logic [95:0] offs, logic [5:0] edges);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= offs;
    s_axis_tuser <= edges;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(predict_weights(offs, edges));
  endtask

  task automatic write_spacing(logic [csnw_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    spacing[idx] = val;
    @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (csnw_pkg::STAGES + 4) @(posedge clk);
  endtask

  task automatic run_random(int n);
    for (int k = 0; k < n; k++)
      send_item({pick_offset(), pick_offset(), pick_offset()}, 6'($urandom()));
  endtask

  // receiver side: random stalls, check each result transaction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= !rst && ($urandom_range(0, 99) >= recv_idle);
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [31:0] sp_set[6];
    sb = new();
    cycles = 0;
    send_idle = 21;
    recv_idle = 59;
    for (int i = 0; i < 3; i++) spacing[i] = csnw_pkg::INV_RESET;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset spacing, every edge class, zero, extremes, support edges
    send_item('0, 6'b111111);
    send_item('0, 6'b000000);
    send_item('0, 6'b010101);
    send_item('0, 6'b101010);
    send_item({3{32'h7fff_ffff}}, 6'b111111);
    send_item({3{32'h8000_0000}}, 6'b000000);
    send_item({32'h0001_0000, 32'hffff_0000, 32'h0002_0000}, 6'b110001);
    send_item({32'hfffe_0000, 32'h0000_8000, 32'hffff_8000}, 6'b100111);
    send_item({32'hffff_ffff, 32'h0000_0001, 32'h0000_0000}, 6'b000000);
    send_item({32'h0001_8000, 32'hfffe_8000, 32'h0000_4000}, 6'b011011);
    drain();

    // directed: zero and extreme spacing
    write_spacing(csnw_pkg::REG_INV_X, 32'h0);
    write_spacing(csnw_pkg::REG_INV_Y, 32'hffff_ffff);
    write_spacing(csnw_pkg::REG_INV_Z, 32'h1);
    send_item({32'h0000_0100, 32'h0000_0001, 32'h0001_0000}, 6'b111111);
    send_item({32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000}, 6'b000000);
    send_item({32'h0000_0000, 32'h0000_0002, 32'h4000_0000}, 6'b010110);
    drain();

    // random phases over several spacing settings
    sp_set = '{32'h0001_0000, 32'h0000_8000, 32'h0004_0000, 32'hffff_ffff, 32'h1, 32'h0};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle = 59;
        recv_idle = 21;
      end else if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_spacing(csnw_pkg::REG_INV_X, sp_set[ph]);
      write_spacing(csnw_pkg::REG_INV_Y, ph[0] ? 32'h0002_0000 : $urandom());
      write_spacing(csnw_pkg::REG_INV_Z, sp_set[5 - ph]);
      run_random(120);
      drain();
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
